FILE: rtl/urm_pkg.sv
package urm_pkg;

   localparam int WINDOW_SIZE = 5;
   localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);
   localparam int SORT_CNT_W  = $clog2(2 * WINDOW_SIZE);
   localparam int MEDIAN_IDX  = WINDOW_SIZE / 2;

   localparam int DIST_W   = 13;
   localparam int SINCE_W  = 20;
   localparam int PULSE_W  = 8;
   localparam int ECHO_W   = 16;
   localparam int PROD_W   = 25;
   localparam int Q_W      = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [PROD_W-1:0] DIST_MULT = 25'd281;
   localparam int DIST_SHIFT = 10;

   localparam logic [SINCE_W-1:0] INTERVAL_RESET  = 20'd60000;
   localparam logic [PULSE_W-1:0] TRIG_RESET      = 8'd10;
   localparam logic [DIST_W-1:0]  MIN_DIST_RESET  = 13'd32;
   localparam logic [DIST_W-1:0]  MAX_DIST_RESET  = 13'd6400;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST = 2'd3;

   typedef logic [DIST_W-1:0] dist_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
      logic overflow;
   } med_stat_type;

endpackage

FILE: rtl/ultrasonic_ranger_median_unit.sv
// channel  | ports                         | direction | accepted when
// req      | req_valid/req_stall, 2 fields | in        | req_valid && !req_stall
// rsp      | rsp_valid/rsp_stall, 6 fields | out       | rsp_valid && !rsp_stall
// csr      | csr_wr_en/index/wdata         | in        | csr_wr_en
// one item per cycle while req_stall is low; its result lands in the output
// register at the accept edge, but an item whose read fills or slides a full window
// gets its result from the sorting cell chain: feed the window, let the chain settle
// synchronous reset restores register defaults and idles; window data is not cleared
// req_stall rises while sorting or while a result is held by rsp_stall
module ultrasonic_ranger_median_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_echo_level,
   input  logic                              req_read_req,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_trig_level,
   output logic                              rsp_result_pending,
   output logic                              rsp_raw_valid,
   output logic [urm_pkg::DIST_W-1:0]        rsp_raw_distance,
   output logic                              rsp_median_valid,
   output logic [urm_pkg::DIST_W-1:0]        rsp_median_distance,
   input  logic                              csr_wr_en,
   input  logic [urm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [urm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_TIME,
      PH_READY
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [urm_pkg::SINCE_W-1:0]  since_ff, since_in;
   logic [urm_pkg::PULSE_W-1:0]  pulse_ff, pulse_in;
   logic [urm_pkg::ECHO_W-1:0]   echo_ff, echo_in;
   urm_pkg::dist_type            held_dist_ff, held_dist_in;
   logic                         held_ok_ff, held_ok_in;

   logic [urm_pkg::SINCE_W-1:0]  interval_ff;
   logic [urm_pkg::PULSE_W-1:0]  trig_width_ff;
   urm_pkg::dist_type            min_dist_ff;
   urm_pkg::dist_type            max_dist_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_trig_ff;
   logic                         rsp_pending_ff;
   logic                         rsp_raw_valid_ff;
   urm_pkg::dist_type            rsp_raw_dist_ff;
   logic                         rsp_med_valid_ff;
   urm_pkg::dist_type            rsp_med_dist_ff;

   logic                         accept;
   logic                         rsp_free;
   logic                         raw_valid;
   urm_pkg::dist_type            raw_dist;
   logic                         push;
   logic [urm_pkg::PROD_W-1:0]   prod;
   logic [urm_pkg::Q_W-1:0]      q;
   urm_pkg::med_stat_type        med_stat;
   urm_pkg::dist_type            median;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = med_stat.busy || !rsp_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_in     = phase_ff;
      since_in     = (since_ff == '1) ? since_ff : since_ff + 1'b1;
      pulse_in     = pulse_ff;
      echo_in      = echo_ff;
      held_dist_in = held_dist_ff;
      held_ok_in   = held_ok_ff;
      raw_valid    = 1'b0;
      raw_dist     = '0;
      push         = 1'b0;
      prod         = '0;
      q            = '0;
      if (phase_ff == PH_READY && req_read_req) begin
         phase_in = PH_IDLE;
         if (held_ok_ff) begin
            raw_valid = 1'b1;
            raw_dist  = held_dist_ff;
            push      = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (since_ff >= interval_ff) begin
                  pulse_in = '0;
                  phase_in = PH_TRIG;
               end
            end
            PH_TRIG: begin
               pulse_in = (pulse_ff == '1) ? pulse_ff : pulse_ff + 1'b1;
               if (pulse_in >= trig_width_ff) begin
                  phase_in = PH_WAIT;
               end
            end
            PH_WAIT: begin
               if (req_echo_level) begin
                  echo_in  = '0;
                  phase_in = PH_TIME;
               end
            end
            PH_TIME: begin
               echo_in = (echo_ff == '1) ? echo_ff : echo_ff + 1'b1;
               if (!req_echo_level) begin
                  prod = urm_pkg::PROD_W'(echo_in) * urm_pkg::DIST_MULT;
                  q    = prod[urm_pkg::PROD_W-1:urm_pkg::DIST_SHIFT];
                  if (q >= urm_pkg::Q_W'(min_dist_ff) && q <= urm_pkg::Q_W'(max_dist_ff)) begin
                     held_ok_in   = 1'b1;
                     held_dist_in = q[urm_pkg::DIST_W-1:0];
                  end else begin
                     held_ok_in   = 1'b0;
                     held_dist_in = '0;
                  end
                  since_in = '0;
                  phase_in = PH_READY;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= urm_pkg::INTERVAL_RESET;
         trig_width_ff <= urm_pkg::TRIG_RESET;
         min_dist_ff   <= urm_pkg::MIN_DIST_RESET;
         max_dist_ff   <= urm_pkg::MAX_DIST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            urm_pkg::CSR_INTERVAL: interval_ff   <= csr_wdata;
            urm_pkg::CSR_TRIG:     trig_width_ff <= csr_wdata[urm_pkg::PULSE_W-1:0];
            urm_pkg::CSR_MIN_DIST: min_dist_ff   <= csr_wdata[urm_pkg::DIST_W-1:0];
            urm_pkg::CSR_MAX_DIST: max_dist_ff   <= csr_wdata[urm_pkg::DIST_W-1:0];
            default:               interval_ff   <= interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         since_ff     <= '0;
         pulse_ff     <= '0;
         echo_ff      <= '0;
         held_dist_ff <= '0;
         held_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            since_ff     <= since_in;
            pulse_ff     <= pulse_in;
            echo_ff      <= echo_in;
            held_dist_ff <= held_dist_in;
            held_ok_ff   <= held_ok_in;
         end
         if (accept && !med_stat.start) begin
            rsp_valid_ff <= 1'b1;
         end else if (med_stat.done && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !med_stat.start) begin
         rsp_trig_ff      <= (phase_in == PH_TRIG);
         rsp_pending_ff   <= (phase_in == PH_READY);
         rsp_raw_valid_ff <= raw_valid;
         rsp_raw_dist_ff  <= raw_dist;
         rsp_med_valid_ff <= 1'b0;
         rsp_med_dist_ff  <= '0;
      end else if (med_stat.done && rsp_free) begin
         rsp_trig_ff      <= 1'b0;
         rsp_pending_ff   <= 1'b0;
         rsp_raw_valid_ff <= 1'b1;
         rsp_raw_dist_ff  <= held_dist_ff;
         rsp_med_valid_ff <= 1'b1;
         rsp_med_dist_ff  <= median;
      end
   end

   urm_median_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && push),
      .push_data (raw_dist),
      .take      (rsp_free),
      .stat      (med_stat),
      .median    (median)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_trig_level      = rsp_trig_ff;
   assign rsp_result_pending  = rsp_pending_ff;
   assign rsp_raw_valid       = rsp_raw_valid_ff;
   assign rsp_raw_distance    = rsp_raw_dist_ff;
   assign rsp_median_valid    = rsp_med_valid_ff;
   assign rsp_median_distance = rsp_med_dist_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !med_stat.overflow)
      else $error("sort chain passed a value past its last cell");

   a_sort_follows: assert property (@(posedge clock) disable iff (reset)
      accept && med_stat.start |=> med_stat.busy && req_stall)
      else $error("median sort did not start after a full window push");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      med_stat.busy |-> !accept)
      else $error("item accepted while sorting");

   a_median_has_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_median_valid |-> rsp_raw_valid && !rsp_trig_level)
      else $error("median result without a raw read");

endmodule

FILE: rtl/urm_sort_cell.sv
module urm_sort_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              in_valid,
   input  urm_pkg::dist_type in_data,
   output logic              pass_valid,
   output urm_pkg::dist_type pass_data,
   output urm_pkg::dist_type held_data
);

   logic              full_ff;
   logic              pass_valid_ff;
   urm_pkg::dist_type held_ff;
   urm_pkg::dist_type pass_data_ff;
   logic              smaller;

   assign smaller = in_data < held_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         full_ff       <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         pass_valid_ff <= in_valid && full_ff;
         if (in_valid && !full_ff) begin
            full_ff <= 1'b1;
         end
      end
   end

   // keep the smaller value, hand the larger one on
   always_ff @(posedge clock) begin
      if (in_valid) begin
         if (!full_ff || smaller) begin
            held_ff <= in_data;
         end
         pass_data_ff <= smaller ? held_ff : in_data;
      end
   end

   assign pass_valid = pass_valid_ff;
   assign pass_data  = pass_data_ff;
   assign held_data  = held_ff;

endmodule

FILE: rtl/urm_median_chain.sv
module urm_median_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  urm_pkg::dist_type     push_data,
   input  logic                  take,
   output urm_pkg::med_stat_type stat,
   output urm_pkg::dist_type     median
);

   localparam logic [urm_pkg::FILL_W-1:0] FILL_FULL =
      urm_pkg::FILL_W'(urm_pkg::WINDOW_SIZE);
   localparam logic [urm_pkg::FILL_W-1:0] FILL_LAST =
      urm_pkg::FILL_W'(urm_pkg::WINDOW_SIZE - 1);
   localparam logic [urm_pkg::SORT_CNT_W-1:0] FEED_END =
      urm_pkg::SORT_CNT_W'(urm_pkg::WINDOW_SIZE);
   localparam logic [urm_pkg::SORT_CNT_W-1:0] SORT_LAST =
      urm_pkg::SORT_CNT_W'(2 * urm_pkg::WINDOW_SIZE - 1);

   urm_pkg::dist_type win_ff [urm_pkg::WINDOW_SIZE];
   logic [urm_pkg::FILL_W-1:0]     fill_ff;
   logic                           busy_ff;
   logic [urm_pkg::SORT_CNT_W-1:0] cnt_ff;

   logic              start;
   logic              feed;
   logic              done;
   logic              pass_valid [urm_pkg::WINDOW_SIZE + 1];
   urm_pkg::dist_type pass_data  [urm_pkg::WINDOW_SIZE + 1];
   urm_pkg::dist_type held_data  [urm_pkg::WINDOW_SIZE];

   assign start = push && (fill_ff >= FILL_LAST);
   assign feed  = busy_ff && (cnt_ff < FEED_END);
   assign done  = busy_ff && (cnt_ff == SORT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (push && (fill_ff != FILL_FULL)) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (done) begin
               if (take) begin
                  busy_ff <= 1'b0;
               end
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   // window: shift in on push, rotate through the sorter while feeding
   always_ff @(posedge clock) begin
      if (push || feed) begin
         for (int i = 0; i < urm_pkg::WINDOW_SIZE - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[urm_pkg::WINDOW_SIZE-1] <= push ? push_data : win_ff[0];
      end
   end

   assign pass_valid[0] = feed;
   assign pass_data[0]  = win_ff[0];

   for (genvar g = 0; g < urm_pkg::WINDOW_SIZE; g++) begin : g_cell
      urm_sort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (start),
         .in_valid   (pass_valid[g]),
         .in_data    (pass_data[g]),
         .pass_valid (pass_valid[g+1]),
         .pass_data  (pass_data[g+1]),
         .held_data  (held_data[g])
      );
   end

   assign stat.start    = start;
   assign stat.busy     = busy_ff;
   assign stat.done     = done;
   assign stat.overflow = pass_valid[urm_pkg::WINDOW_SIZE];
   assign median        = held_data[urm_pkg::MEDIAN_IDX];

endmodule
